FILE: rtl/core/hrsp_pkg.sv
// Shared types, character codes and hex digit decode for the hex record stream parser.
`default_nettype none

package hrsp_pkg;

   // Character codes
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_RETURN  = 8'h0D;

   // Record type codes
   localparam logic [7:0] TYPE_DATA = 8'h00;
   localparam logic [7:0] TYPE_EOF  = 8'h01;

   // Reset value of the stop-on-error register
   localparam logic STOP_ON_ERROR_RESET = 1'b1;

   // Result kinds
   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   // Record status codes
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_NO_COLON  = 3'd1,
      STATUS_BAD_DIGIT = 3'd2,
      STATUS_SHORT     = 3'd3,
      STATUS_CHECKSUM  = 3'd4,
      STATUS_EOF       = 3'd5
   } status_type;

   // Parser phase, one-hot
   typedef enum logic [7:0] {
      PH_WAIT  = 8'b0000_0001,
      PH_COUNT = 8'b0000_0010,
      PH_ADDR  = 8'b0000_0100,
      PH_TYPE  = 8'b0000_1000,
      PH_DATA  = 8'b0001_0000,
      PH_CSUM  = 8'b0010_0000,
      PH_TAIL  = 8'b0100_0000,
      PH_SKIP  = 8'b1000_0000
   } phase_type;

   // One result item
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic [15:0] address;
      logic [7:0] record_code;
      status_type status;
      logic       halted;
   } result_type;

   // Hex digit decode: valid flag and nibble value
   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } nibble_type;

   function automatic nibble_type hex_decode(input logic [7:0] c);
      nibble_type n;
      n.valid = 1'b1;
      n.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         n.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         n.value = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         n.value = 4'(c - 8'h57);
      end else begin
         n.valid = 1'b0;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hex_record_stream_parser.sv
// Top level of the hex record stream parser: character decode, record state and result queue.
`default_nettype none

// Takes one ASCII character per transfer on the req_ channel (or an end-of-input
// marker) and returns data-byte results for type-00 records and one status result
// per record on the rsp_ channel. Every character is decoded and folded into the
// record state in the cycle it is taken, so one character transfers per clock
// while req_stall is low; results are registered into a two-entry queue and
// reach rsp_ in order: req_stall rises only when both entries hold results that
// rsp_ has not taken. csr_ writes the stop-on-error bit (reset 1) and are always
// taken; write it only while the parser is idle.
module hex_record_stream_parser
   import hrsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Character channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_end_of_input,
   // Result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [15:0]      rsp_address,
   output logic [7:0]       rsp_record_code,
   output logic [2:0]       rsp_status,
   output logic             rsp_halted,
   // Configuration write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_wdata
);

   // Record state
   phase_type   phase_ff, phase_in;
   logic [1:0]  digit_count_ff, digit_count_in;
   logic [3:0]  high_nibble_ff, high_nibble_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [15:0] base_address_ff, base_address_in;
   logic [7:0]  type_code_ff, type_code_in;
   logic [7:0]  data_index_ff, data_index_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic        stopped_ff, stopped_in;
   logic        stop_on_error_ff;

   // Result queue
   result_type  slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0]  count_ff, count_in;

   logic        req_take, rsp_take;
   logic        res_valid;
   result_type  res;
   nibble_type  nib;
   logic [7:0]  byte_val;
   logic [1:0]  digit_count_inc;
   logic [7:0]  data_index_inc;
   status_type  verdict;

   // Finish request from the decode
   logic        fin;
   status_type  fin_status;
   logic        fin_newline;
   logic [15:0] fin_address;
   logic [7:0]  fin_type;
   logic        fin_stop;

   assign req_stall = (count_ff == 2'd2);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign csr_ready = 1'b1;

   assign nib             = hex_decode(req_ch);
   assign byte_val        = {high_nibble_ff, nib.value};
   assign digit_count_inc = digit_count_ff + 2'd1;
   assign data_index_inc  = data_index_ff + 8'd1;
   assign verdict         = (running_sum_ff != 8'd0) ? STATUS_CHECKSUM :
                            (type_code_ff == TYPE_EOF) ? STATUS_EOF : STATUS_OK;

   // Decode one character against the record state
   always_comb begin
      phase_in        = phase_ff;
      digit_count_in  = digit_count_ff;
      high_nibble_in  = high_nibble_ff;
      byte_count_in   = byte_count_ff;
      base_address_in = base_address_ff;
      type_code_in    = type_code_ff;
      data_index_in   = data_index_ff;
      running_sum_in  = running_sum_ff;
      stopped_in      = stopped_ff;
      res_valid       = 1'b0;
      res             = '{kind: KIND_STATUS, data_byte: 8'd0, address: 16'd0,
                          record_code: 8'd0, status: STATUS_OK, halted: 1'b0};
      fin             = 1'b0;
      fin_status      = STATUS_OK;
      fin_newline     = 1'b0;
      fin_address     = base_address_ff;
      fin_type        = type_code_ff;
      fin_stop        = 1'b0;

      if (req_end_of_input) begin
         // End of input: report a record in progress unless halted, then clear the record state and the halt
         if (!stopped_ff) begin
            if (phase_ff == PH_COUNT || phase_ff == PH_ADDR || phase_ff == PH_TYPE ||
                phase_ff == PH_DATA || phase_ff == PH_CSUM) begin
               res_valid  = 1'b1;
               res.status = STATUS_SHORT;
            end else if (phase_ff == PH_TAIL) begin
               res_valid  = 1'b1;
               res.status = verdict;
            end
         end
         res.address     = base_address_ff;
         res.record_code = type_code_ff;
         stopped_in      = 1'b0;
         phase_in        = PH_WAIT;
         digit_count_in  = 2'd0;
         high_nibble_in  = 4'd0;
         byte_count_in   = 8'd0;
         base_address_in = 16'd0;
         type_code_in    = 8'd0;
         data_index_in   = 8'd0;
         running_sum_in  = 8'd0;
      end else if (!stopped_ff && req_ch != CHAR_RETURN) begin
         unique case (phase_ff)
            PH_WAIT: begin
               if (req_ch == CHAR_COLON) begin
                  digit_count_in  = 2'd0;
                  high_nibble_in  = 4'd0;
                  byte_count_in   = 8'd0;
                  base_address_in = 16'd0;
                  type_code_in    = 8'd0;
                  data_index_in   = 8'd0;
                  running_sum_in  = 8'd0;
                  phase_in        = PH_COUNT;
               end else if (req_ch != CHAR_NEWLINE) begin
                  fin         = 1'b1;
                  fin_status  = STATUS_NO_COLON;
                  fin_address = 16'd0;
                  fin_type    = 8'd0;
               end
            end
            PH_SKIP: begin
               if (req_ch == CHAR_NEWLINE) begin
                  phase_in = PH_WAIT;
               end
            end
            PH_TAIL: begin
               if (req_ch == CHAR_NEWLINE) begin
                  fin         = 1'b1;
                  fin_status  = verdict;
                  fin_newline = 1'b1;
               end
            end
            PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CSUM: begin
               if (req_ch == CHAR_NEWLINE) begin
                  fin         = 1'b1;
                  fin_status  = STATUS_SHORT;
                  fin_newline = 1'b1;
               end else if (!nib.valid) begin
                  fin        = 1'b1;
                  fin_status = STATUS_BAD_DIGIT;
               end else begin
                  if (phase_ff == PH_ADDR) begin
                     base_address_in = {base_address_ff[11:0], nib.value};
                  end
                  digit_count_in = digit_count_inc;
                  if (!digit_count_ff[0]) begin
                     high_nibble_in = nib.value;
                  end else begin
                     running_sum_in = running_sum_ff + byte_val;
                     unique case (phase_ff)
                        PH_COUNT: begin
                           byte_count_in  = byte_val;
                           digit_count_in = 2'd0;
                           phase_in       = PH_ADDR;
                        end
                        PH_ADDR: begin
                           if (digit_count_inc == 2'd0) begin
                              phase_in = PH_TYPE;
                           end
                        end
                        PH_TYPE: begin
                           type_code_in   = byte_val;
                           digit_count_in = 2'd0;
                           phase_in       = (byte_count_ff != 8'd0) ? PH_DATA : PH_CSUM;
                        end
                        PH_DATA: begin
                           digit_count_in = 2'd0;
                           data_index_in  = data_index_inc;
                           if (data_index_inc == byte_count_ff) begin
                              phase_in = PH_CSUM;
                           end
                           if (type_code_ff == TYPE_DATA) begin
                              res_valid     = 1'b1;
                              res.kind      = KIND_DATA;
                              res.data_byte = byte_val;
                              res.address   = base_address_ff + {8'd0, data_index_ff};
                              res.halted    = stopped_ff;
                           end
                        end
                        default: begin
                           digit_count_in = 2'd0;
                           phase_in       = PH_TAIL;
                        end
                     endcase
                  end
               end
            end
            default: begin
               phase_in = PH_WAIT;
            end
         endcase

         // Report the record, then halt, skip or wait
         if (fin) begin
            fin_stop = (fin_status == STATUS_EOF) ||
                       (fin_status != STATUS_OK && stop_on_error_ff);
            if (fin_stop) begin
               stopped_in = 1'b1;
            end
            phase_in        = (fin_newline || fin_stop) ? PH_WAIT : PH_SKIP;
            res_valid       = 1'b1;
            res.kind        = KIND_STATUS;
            res.address     = fin_address;
            res.record_code = fin_type;
            res.status      = fin_status;
            res.halted      = fin_stop;
         end
      end
   end

   // Queue next state: push new results behind the head, advance on a take
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      unique case (count_ff)
         2'd0: begin
            if (req_take && res_valid) begin
               slot0_in = res;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (req_take && res_valid) begin
               if (rsp_take) begin
                  slot0_in = res;
               end else begin
                  slot1_in = res;
                  count_in = 2'd2;
               end
            end else if (rsp_take) begin
               count_in = 2'd0;
            end
         end
         default: begin
            if (rsp_take) begin
               slot0_in = slot1_ff;
               count_in = 2'd1;
            end
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_WAIT;
         digit_count_ff   <= 2'd0;
         high_nibble_ff   <= 4'd0;
         byte_count_ff    <= 8'd0;
         base_address_ff  <= 16'd0;
         type_code_ff     <= 8'd0;
         data_index_ff    <= 8'd0;
         running_sum_ff   <= 8'd0;
         stopped_ff       <= 1'b0;
         stop_on_error_ff <= STOP_ON_ERROR_RESET;
         count_ff         <= 2'd0;
      end else begin
         if (req_take) begin
            phase_ff        <= phase_in;
            digit_count_ff  <= digit_count_in;
            high_nibble_ff  <= high_nibble_in;
            byte_count_ff   <= byte_count_in;
            base_address_ff <= base_address_in;
            type_code_ff    <= type_code_in;
            data_index_ff   <= data_index_in;
            running_sum_ff  <= running_sum_in;
            stopped_ff      <= stopped_in;
         end
         if (csr_valid && csr_ready) begin
            stop_on_error_ff <= csr_wdata;
         end
         count_ff <= count_in;
      end
   end

   // Queue payload, no reset
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_kind        = slot0_ff.kind;
   assign rsp_data_byte   = slot0_ff.data_byte;
   assign rsp_address     = slot0_ff.address;
   assign rsp_record_code = slot0_ff.record_code;
   assign rsp_status      = slot0_ff.status;
   assign rsp_halted      = slot0_ff.halted;

   // Queue never overfills
   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("result queue count out of range");

   // A taken end of input leaves the parser idle and running
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_end_of_input) |=> (phase_ff == PH_WAIT && !stopped_ff))
      else $error("end of input did not clear the parser");

   // A halted parser waits for end of input in the idle phase
   assert property (@(posedge clock) disable iff (reset) stopped_ff |-> phase_ff == PH_WAIT)
      else $error("halted parser outside idle phase");

   // Full queue holds its head until taken
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && rsp_stall) |=> (count_ff == 2'd2 && $stable(slot0_ff)))
      else $error("stalled result queue changed");

endmodule

`default_nettype wire

FILE: tb/tb_hex_record_stream_parser.sv
// Self-checking testbench for the hex record stream parser.
`timescale 1ns / 1ps

module tb_hex_record_stream_parser;
   import hrsp_pkg::*;

   // Scoreboard: mirrors the parser state and holds the results still owed by the block
   class record_board;
      bit          stop_on_error;
      bit          halted;
      phase_type   phase;
      logic [1:0]  digit_cnt;
      logic [3:0]  hi_nib;
      logic [7:0]  count_byte;
      logic [15:0] rec_addr;
      logic [7:0]  rec_type;
      logic [7:0]  data_idx;
      logic [7:0]  byte_sum;
      result_type  expected_q[$];
      int          errors;

      function new();
         stop_on_error = STOP_ON_ERROR_RESET;
         halted = 1'b0;
         phase = PH_WAIT;
         errors = 0;
         clear_record();
      endfunction

      function void clear_record();
         digit_cnt = '0;
         hi_nib = '0;
         count_byte = '0;
         rec_addr = '0;
         rec_type = '0;
         data_idx = '0;
         byte_sum = '0;
      endfunction

      static function bit hex_digit(input logic [7:0] c, output logic [3:0] v);
         v = '0;
         if (c >= "0" && c <= "9") v = 4'(c - "0");
         else if (c >= "A" && c <= "F") v = 4'(c - "A" + 8'd10);
         else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
         else return 1'b0;
         return 1'b1;
      endfunction

      function void push_result(kind_type k, logic [7:0] b, logic [15:0] a,
                                logic [7:0] t, status_type s);
         result_type r;
         r.kind = k;
         r.data_byte = b;
         r.address = a;
         r.record_code = t;
         r.status = s;
         r.halted = halted;
         expected_q.push_back(r);
      endfunction

      function status_type verdict();
         if (byte_sum != 8'h00) return STATUS_CHECKSUM;
         return (rec_type == TYPE_EOF) ? STATUS_EOF : STATUS_OK;
      endfunction

      // Report a finished or broken record, then halt, skip the line or wait
      function void close_record(status_type s, bit at_newline, logic [15:0] a,
                                 logic [7:0] t);
         if (s == STATUS_EOF || (s != STATUS_OK && stop_on_error)) halted = 1'b1;
         phase = (at_newline || halted) ? PH_WAIT : PH_SKIP;
         push_result(KIND_STATUS, 8'h00, a, t, s);
      endfunction

      // Fold one accepted transfer into the state; return 0 if the block ignores it
      function bit take_item(input logic [7:0] c, input logic eoi);
         logic [3:0] nib;
         logic [7:0] value;
         logic [15:0] a;
         status_type s;
         bit have;
         if (eoi) begin
            have = 1'b0;
            s = STATUS_OK;
            a = rec_addr;
            value = rec_type;
            if (!halted) begin
               case (phase)
                  PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CSUM: begin
                     s = STATUS_SHORT;
                     have = 1'b1;
                  end
                  PH_TAIL: begin
                     s = verdict();
                     have = 1'b1;
                  end
                  default: ;
               endcase
            end
            halted = 1'b0;
            phase = PH_WAIT;
            clear_record();
            if (have) push_result(KIND_STATUS, 8'h00, a, value, s);
            return 1'b1;
         end
         if (halted) return 1'b0;
         if (c == CHAR_RETURN) return 1'b1;

         case (phase)
            PH_WAIT: begin
               if (c == CHAR_COLON) begin
                  clear_record();
                  phase = PH_COUNT;
               end else if (c != CHAR_NEWLINE) begin
                  close_record(STATUS_NO_COLON, 1'b0, 16'h0000, 8'h00);
               end
               return 1'b1;
            end
            PH_SKIP: begin
               if (c == CHAR_NEWLINE) phase = PH_WAIT;
               return 1'b1;
            end
            PH_TAIL: begin
               if (c == CHAR_NEWLINE) close_record(verdict(), 1'b1, rec_addr, rec_type);
               return 1'b1;
            end
            default: ;
         endcase

         if (c == CHAR_NEWLINE) begin
            close_record(STATUS_SHORT, 1'b1, rec_addr, rec_type);
            return 1'b1;
         end
         if (!hex_digit(c, nib)) begin
            close_record(STATUS_BAD_DIGIT, 1'b0, rec_addr, rec_type);
            return 1'b1;
         end

         if (phase == PH_ADDR) rec_addr = {rec_addr[11:0], nib};
         if (digit_cnt[0] == 1'b0) begin
            hi_nib = nib;
            digit_cnt = digit_cnt + 2'd1;
            return 1'b1;
         end
         value = {hi_nib, nib};
         byte_sum = byte_sum + value;
         digit_cnt = digit_cnt + 2'd1;

         // Advance through the record fields one byte at a time
         case (phase)
            PH_COUNT: begin
               count_byte = value;
               digit_cnt = '0;
               phase = PH_ADDR;
            end
            PH_ADDR: begin
               if (digit_cnt == 2'd0) phase = PH_TYPE;
            end
            PH_TYPE: begin
               rec_type = value;
               digit_cnt = '0;
               phase = (count_byte != 8'h00) ? PH_DATA : PH_CSUM;
            end
            PH_DATA: begin
               a = rec_addr + 16'(data_idx);
               digit_cnt = '0;
               data_idx = data_idx + 8'd1;
               if (data_idx == count_byte) phase = PH_CSUM;
               if (rec_type == TYPE_DATA) push_result(KIND_DATA, value, a, 8'h00, STATUS_OK);
            end
            default: begin
               digit_cnt = '0;
               phase = PH_TAIL;
            end
         endcase
         return 1'b1;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report_mismatch(input string msg);
         errors++;
         if (errors <= 30) $display("%0t ns: mismatch: %s", $realtime, msg);
      endtask

      // Compare one transfer on the result channel with the oldest expectation
      task check_result(input result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
            return;
         end
         want = expected_q.pop_front();
         if (got.kind != want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
         if (got.data_byte != want.data_byte)
            report_mismatch($sformatf("data_byte %h, want %h", got.data_byte, want.data_byte));
         if (got.address != want.address)
            report_mismatch($sformatf("address %h, want %h", got.address, want.address));
         if (got.record_code != want.record_code)
            report_mismatch($sformatf("record_code %h, want %h",
                                      got.record_code, want.record_code));
         if (got.status != want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.halted != want.halted)
            report_mismatch($sformatf("halted %0d, want %0d", got.halted, want.halted));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch = 8'h00;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [15:0] rsp_address;
   logic [7:0]  rsp_record_code;
   logic [2:0]  rsp_status;
   logic        rsp_halted;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_wdata = 1'b0;

   int          send_gap = 0;
   int          recv_gap = 0;
   int          live_items = 0;
   result_type  seen;
   record_board board = new();

   hex_record_stream_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ch           (req_ch),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_address      (rsp_address),
      .rsp_record_code  (rsp_record_code),
      .rsp_status       (rsp_status),
      .rsp_halted       (rsp_halted),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_gap);
   end

   // Check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = result_type'({rsp_kind, rsp_data_byte, rsp_address, rsp_record_code,
                              rsp_status, rsp_halted});
         board.check_result(seen);
      end
   end

   function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
   endfunction

   // Hold one character on the req_ channel until it transfers
   task drive_item(input logic [7:0] c, input logic eoi);
      while ($urandom_range(99) < send_gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      req_end_of_input <= eoi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (board.take_item(c, eoi)) live_items++;
   endtask

   task send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) drive_item(s[i], 1'b0);
   endtask

   task send_eoi();
      drive_item(8'($urandom_range(255)), 1'b1);
   endtask

   // Drop valid and let every owed result drain out
   task wait_idle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_stop(input logic v);
      wait_idle();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.stop_on_error = v;
   endtask

   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      logic [3:0] v;
      do c = 8'($urandom_range(255));
      while (record_board::hex_digit(c, v) || c == CHAR_NEWLINE || c == CHAR_RETURN);
      return c;
   endfunction

   // Build one record with random content, maybe break it, and send it
   task send_random_record();
      logic [7:0]  rec[$];
      logic [7:0]  text[$];
      logic [7:0]  sum;
      logic [7:0]  rtype;
      logic [15:0] addr;
      int          n, i, pick, cut;
      bit          end_by_eoi;
      n = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 6);
      addr = ($urandom_range(3) == 0) ? 16'hFFFF - 16'($urandom_range(3)) : 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 70) rtype = TYPE_DATA;
      else if (pick < 80) rtype = TYPE_EOF;
      else if (pick < 95) rtype = 8'($urandom_range(2, 5));
      else rtype = 8'($urandom_range(255));
      rec = '{8'(n), addr[15:8], addr[7:0], rtype};
      for (i = 0; i < n; i++) rec.push_back(8'($urandom_range(255)));
      sum = 8'h00;
      foreach (rec[k]) sum = sum + rec[k];
      rec.push_back(8'h00 - sum);

      pick = $urandom_range(99);
      if (pick >= 60 && pick < 70) rec[rec.size() - 1] ^= 8'($urandom_range(1, 255));

      text.push_back(CHAR_COLON);
      foreach (rec[k]) begin
         text.push_back(hex_char(rec[k][7:4], 1'($urandom_range(1))));
         text.push_back(hex_char(rec[k][3:0], 1'($urandom_range(1))));
      end
      end_by_eoi = ($urandom_range(99) < 15);

      // Break the record as the pick says
      if (pick >= 70 && pick < 80) begin
         text[$urandom_range(1, text.size() - 1)] = non_hex_char();
      end else if (pick >= 80 && pick < 90) begin
         cut = $urandom_range(1, text.size() - 1);
         text = text[0:cut - 1];
      end else if (pick >= 90) begin
         for (i = 0; i < $urandom_range(1, 3); i++)
            text.insert($urandom_range(1, text.size()), CHAR_RETURN);
      end else if ($urandom_range(3) == 0) begin
         for (i = 0; i < $urandom_range(1, 4); i++) begin
            do cut = $urandom_range(255);
            while (cut == CHAR_NEWLINE);
            text.push_back(8'(cut));
         end
      end

      foreach (text[k]) drive_item(text[k], 1'b0);
      if (end_by_eoi) send_eoi();
      else drive_item(CHAR_NEWLINE, 1'b0);
   endtask

   // Mostly well-formed records, with stray lines, noise and end-of-input marks
   task run_random(input int n_items);
      int pick, i;
      logic [7:0] c;
      live_items = 0;
      while (live_items < n_items) begin
         if (board.halted) begin
            if ($urandom_range(3) != 0) send_eoi();
            else drive_item(8'($urandom_range(255)), 1'b0);
         end else begin
            pick = $urandom_range(99);
            if (pick < 80) begin
               send_random_record();
            end else if (pick < 87) begin
               do c = 8'($urandom_range(255));
               while (c == CHAR_COLON || c == CHAR_NEWLINE || c == CHAR_RETURN);
               drive_item(c, 1'b0);
               for (i = 0; i < $urandom_range(0, 5); i++)
                  drive_item(8'($urandom_range(255)), 1'b0);
               drive_item(CHAR_NEWLINE, 1'b0);
            end else if (pick < 92) begin
               send_text(($urandom_range(1) != 0) ? "\r\n" : "\n");
            end else if (pick < 97) begin
               for (i = 0; i < $urandom_range(1, 8); i++)
                  drive_item(8'($urandom_range(255)), 1'b0);
            end else begin
               send_eoi();
            end
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: blank line with carriage return, end-of-file record at the top
      // address with trailing text, no colon while halting on error
      send_text("\r\n");
      send_text(":00FFFF0101x\n");
      send_eoi();
      send_text("G");
      send_eoi();

      // Directed with skip on error: short record ended by end of input, data byte
      // at the top address, bad digit, checksum mismatch, other type closed by
      // end of input
      write_stop(1'b0);
      send_text(":FF");
      send_eoi();
      send_text(":01ffff00ab56\n");
      send_text(":0z\n");
      send_text(":0000000001\n");
      send_text(":00000002FE");
      send_eoi();

      write_stop(1'b1);
      send_gap = 30;
      recv_gap = 49;
      run_random(120);

      write_stop(1'b0);
      send_gap = 49;
      recv_gap = 30;
      run_random(120);

      write_stop(1'b1);
      send_gap = 0;
      recv_gap = 0;
      run_random(120);

      wait_idle();
      repeat (10) @(posedge clock);
      if (board.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
